// ===== src/rdq_pkg.sv =====
package rdq_pkg;

    // Cell targets are compared at this width, enough for the largest capacity.
    localparam int TARGET_W = 12;

    typedef enum logic [3:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_POP_BACK   = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_READ       = 4'd4,
        CMD_WRITE      = 4'd5,
        CMD_INSERT     = 4'd6,
        CMD_ERASE      = 4'd7,
        CMD_CLEAR      = 4'd8,
        CMD_FIND       = 4'd9,
        CMD_REMOVE     = 4'd10
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_RANGE    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_ERASE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [TARGET_W-1:0]   target;
    } cell_ctl_t;

endpackage

// ===== src/rdq_cell.sv =====
module rdq_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  rdq_pkg::cell_ctl_t    ctl,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = ctl.target == rdq_pkg::TARGET_W'(INDEX);
    assign above = rdq_pkg::TARGET_W'(INDEX) > ctl.target;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            rdq_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            rdq_pkg::CELL_WRITE:
            begin
                if (hit)
                begin
                    data_next = wdata;
                end
            end
            rdq_pkg::CELL_INSERT:
            begin
                // Cells above the target move one place toward the back.
                if (hit)
                begin
                    data_next = wdata;
                end
                else if (above)
                begin
                    data_next = left_data;
                end
            end
            rdq_pkg::CELL_ERASE:
            begin
                if (hit || above)
                begin
                    data_next = right_data;
                end
            end
            rdq_pkg::CELL_ROTATE:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== src/ring_deque_indexed_table_core.sv =====
// Channel  Direction  Fields (tdata, lowest bit first)
// s_*      in         command[3:0] position[10:4] value_in[42:11], zero to 48 bits
// m_*      out        value_out[31:0] found_position[37:32] element_count[44:38]
//                     status[47:45]
//
// Elements sit in a row of CAPACITY cells in logical order; cell 0 is the front.
// Push, pop, write, insert, erase and clear take one cycle: the row shifts in place.
// Read, find and remove take that cycle and then rotate the row once through cell 0
// in CAPACITY more cycles, plus one cycle for the erase of a remove that matched.
// Reset empties the table at once; cell contents are not cleared.
// A new transaction is taken while idle and the result register is free or being taken.
module ring_deque_indexed_table_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command, position, value_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // value_out, found_position, element_count, status
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIX
    } state_t;

    state_t                  state_reg,  state_next;
    logic [CNT_W-1:0]        cnt_reg,    cnt_next;
    logic [IDX_W-1:0]        step_reg,   step_next;
    logic                    found_reg,  found_next;
    logic [IDX_W-1:0]        fpos_reg,   fpos_next;
    logic [DATA_WIDTH-1:0]   rd_reg,     rd_next;
    rdq_pkg::cmd_t           cmd_reg,    cmd_next;
    logic [6:0]              pos_reg,    pos_next;
    logic [DATA_WIDTH-1:0]   val_reg,    val_next;
    logic                    ov_reg,     ov_next;
    logic [31:0]             ovalue_reg, ovalue_next;
    logic [5:0]              ofp_reg,    ofp_next;
    logic [6:0]              ocnt_reg,   ocnt_next;
    rdq_pkg::status_t        ost_reg,    ost_next;

    logic                    accept;
    rdq_pkg::cmd_t           in_cmd;
    logic [6:0]              in_pos;
    logic [DATA_WIDTH-1:0]   in_val;
    logic [CMP_W-1:0]        pos_w;
    logic [CMP_W-1:0]        cnt_w;
    logic                    full;
    logic                    empty;
    logic                    load_out;
    logic                    scan_last;
    logic                    match;
    rdq_pkg::cell_ctl_t      ctl;
    logic [DATA_WIDTH-1:0]   wdata;
    logic [DATA_WIDTH-1:0]   row [CAPACITY];

    assign s_tready = (state_reg == ST_IDLE) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign in_cmd   = rdq_pkg::cmd_t'(s_tdata[3:0]);
    assign in_pos   = s_tdata[10:4];
    assign in_val   = s_tdata[11 +: DATA_WIDTH];
    assign pos_w    = CMP_W'(in_pos);
    assign cnt_w    = CMP_W'(cnt_reg);
    assign full     = cnt_reg == CNT_W'(CAPACITY);
    assign empty    = cnt_reg == '0;
    assign scan_last = step_reg == IDX_W'(CAPACITY - 1);
    assign match    = (row[0] == val_reg) && (CMP_W'(step_reg) < cnt_w);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = wdata;
            end
            else
            begin : g_mid
                assign left_d = row[gi-1];
            end
            // The last cell wraps to cell 0 so that a full rotation restores the row.
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = row[0];
            end
            else
            begin : g_inner
                assign right_d = row[gi+1];
            end
            rdq_cell #(
                .INDEX      (gi),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .wdata      (wdata),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (row[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        fpos_next   = fpos_reg;
        rd_next     = rd_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        ov_next     = ov_reg && !m_tready;
        ovalue_next = ovalue_reg;
        ofp_next    = ofp_reg;
        ocnt_next   = ocnt_reg;
        ost_next    = ost_reg;
        load_out    = 1'b0;
        ctl.op      = rdq_pkg::CELL_HOLD;
        ctl.target  = '0;
        wdata       = in_val;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_out    = 1'b1;
                    ovalue_next = '0;
                    ofp_next    = '0;
                    ost_next    = rdq_pkg::STAT_OK;
                    unique case (in_cmd) inside
                        rdq_pkg::CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                ost_next = rdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.op     = rdq_pkg::CELL_WRITE;
                                ctl.target = rdq_pkg::TARGET_W'(cnt_reg);
                                cnt_next   = cnt_reg + 1'b1;
                            end
                        end
                        rdq_pkg::CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                ost_next = rdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.op   = rdq_pkg::CELL_INSERT;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        rdq_pkg::CMD_POP_BACK, rdq_pkg::CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                ost_next = rdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                if (in_cmd == rdq_pkg::CMD_POP_FRONT)
                                begin
                                    ctl.op = rdq_pkg::CELL_ERASE;
                                end
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        rdq_pkg::CMD_WRITE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                ost_next = rdq_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                ctl.op     = rdq_pkg::CELL_WRITE;
                                ctl.target = rdq_pkg::TARGET_W'(in_pos);
                            end
                        end
                        rdq_pkg::CMD_INSERT:
                        begin
                            if (pos_w > cnt_w)
                            begin
                                ost_next = rdq_pkg::STAT_RANGE;
                            end
                            else if (full)
                            begin
                                ost_next = rdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctl.op     = rdq_pkg::CELL_INSERT;
                                ctl.target = rdq_pkg::TARGET_W'(in_pos);
                                cnt_next   = cnt_reg + 1'b1;
                            end
                        end
                        rdq_pkg::CMD_ERASE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                ost_next = rdq_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                ctl.op     = rdq_pkg::CELL_ERASE;
                                ctl.target = rdq_pkg::TARGET_W'(in_pos);
                                cnt_next   = cnt_reg - 1'b1;
                            end
                        end
                        rdq_pkg::CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        rdq_pkg::CMD_READ:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                ost_next = rdq_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                load_out   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        rdq_pkg::CMD_FIND, rdq_pkg::CMD_REMOVE:
                        begin
                            load_out   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            ost_next = rdq_pkg::STAT_OK;
                        end
                    endcase
                    cmd_next   = in_cmd;
                    pos_next   = in_pos;
                    val_next   = in_val;
                    step_next  = '0;
                    found_next = 1'b0;
                    fpos_next  = '0;
                    rd_next    = '0;
                    ocnt_next  = 7'(cnt_next);
                end
            end
            ST_SCAN:
            begin
                // Cell 0 holds logical element step_reg during this cycle.
                ctl.op    = rdq_pkg::CELL_ROTATE;
                step_next = step_reg + 1'b1;
                if (CMP_W'(step_reg) == CMP_W'(pos_reg))
                begin
                    rd_next = row[0];
                end
                if (!found_reg && match)
                begin
                    found_next = 1'b1;
                    fpos_next  = step_reg;
                end
                if (scan_last)
                begin
                    if (cmd_reg == rdq_pkg::CMD_REMOVE && found_next)
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        state_next  = ST_IDLE;
                        load_out    = 1'b1;
                        ocnt_next   = 7'(cnt_reg);
                        if (cmd_reg == rdq_pkg::CMD_READ)
                        begin
                            ovalue_next = 32'(rd_next);
                            ofp_next    = '0;
                            ost_next    = rdq_pkg::STAT_OK;
                        end
                        else
                        begin
                            ovalue_next = '0;
                            ofp_next    = found_next ? 6'(fpos_next) : 6'd0;
                            ost_next    = found_next ? rdq_pkg::STAT_OK
                                                     : rdq_pkg::STAT_NOTFOUND;
                        end
                    end
                end
            end
            ST_FIX:
            begin
                ctl.op      = rdq_pkg::CELL_ERASE;
                ctl.target  = rdq_pkg::TARGET_W'(fpos_reg);
                cnt_next    = cnt_reg - 1'b1;
                state_next  = ST_IDLE;
                load_out    = 1'b1;
                ovalue_next = '0;
                ofp_next    = 6'(fpos_reg);
                ocnt_next   = 7'(cnt_next);
                ost_next    = rdq_pkg::STAT_OK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            step_reg   <= '0;
            found_reg  <= 1'b0;
            fpos_reg   <= '0;
            rd_reg     <= '0;
            cmd_reg    <= rdq_pkg::CMD_PUSH_BACK;
            pos_reg    <= '0;
            val_reg    <= '0;
            ov_reg     <= 1'b0;
            ovalue_reg <= '0;
            ofp_reg    <= '0;
            ocnt_reg   <= '0;
            ost_reg    <= rdq_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            found_reg  <= found_next;
            fpos_reg   <= fpos_next;
            rd_reg     <= rd_next;
            cmd_reg    <= cmd_next;
            pos_reg    <= pos_next;
            val_reg    <= val_next;
            ov_reg     <= ov_next;
            ovalue_reg <= ovalue_next;
            ofp_reg    <= ofp_next;
            ocnt_reg   <= ocnt_next;
            ost_reg    <= ost_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {ost_reg, ocnt_reg, ofp_reg, ovalue_reg};

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ov_reg)
        else $error("result register busy during a scan");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_SCAN) |=> (step_reg == '0 && !found_reg))
        else $error("scan did not start from the front");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> ($past(accept) || $past(state_reg) == ST_FIX))
        else $error("count changed outside a command");

    a_fix_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (found_reg && cnt_reg != '0))
        else $error("remove erase without a match");

endmodule

// ===== bench/tb_ring_deque_indexed_table_core.sv =====
`timescale 1ns / 1ps

module tb_ring_deque_indexed_table_core;

    localparam int CAP          = 64;
    localparam int RANDOM_ITEMS = 1200;
    localparam int EPISODE_LEN  = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 600;
    localparam int DRAIN_CYCLES = 100;
    localparam int NUM_ROWS     = 25;

    // Slave side, lowest bit first: command, position, value_in, zero fill.
    typedef struct packed {
        logic [4:0]      pad;
        logic [31:0]     value;
        logic [6:0]      position;
        rdq_pkg::cmd_t   command;
    } cmd_word_t;

    // Master side, lowest bit first: value_out, found_position, element_count, status.
    typedef struct packed {
        rdq_pkg::status_t status;
        logic [6:0]       count;
        logic [5:0]       found;
        logic [31:0]      value;
    } result_word_t;

    typedef struct {
        rdq_pkg::cmd_t cmd;
        logic [6:0]    pos;
        logic [31:0]   value;
        bit            typed;
        result_word_t  want;
    } step_row_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mode_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Logical contents of the deque, front first.
    logic [31:0]  shadow_words[$];
    result_word_t pending_results[$];

    int fail_count     = 0;
    int mismatch_count = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int full_refusals  = 0;
    int peak_count     = 0;
    int search_hits    = 0;
    bit quiet_phase    = 1'b0;

    step_row_t directed_rows[NUM_ROWS];

    ring_deque_indexed_table_core #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (32)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic result_word_t deque_apply(rdq_pkg::cmd_t cmd, logic [6:0] pos,
                                                 logic [31:0] v);
        result_word_t r;
        int           n;
        int           idx;
        int           i;
        r        = '0;
        r.status = rdq_pkg::STAT_OK;
        n        = shadow_words.size();
        idx      = int'(pos);
        case (cmd) inside
            rdq_pkg::CMD_PUSH_BACK, rdq_pkg::CMD_PUSH_FRONT:
            begin
                if (n >= CAP)
                    r.status = rdq_pkg::STAT_FULL;
                else if (cmd == rdq_pkg::CMD_PUSH_BACK)
                    shadow_words.push_back(v);
                else
                    shadow_words.push_front(v);
            end
            rdq_pkg::CMD_POP_BACK, rdq_pkg::CMD_POP_FRONT:
            begin
                if (n == 0)
                    r.status = rdq_pkg::STAT_EMPTY;
                else if (cmd == rdq_pkg::CMD_POP_BACK)
                    void'(shadow_words.pop_back());
                else
                    void'(shadow_words.pop_front());
            end
            rdq_pkg::CMD_READ, rdq_pkg::CMD_WRITE:
            begin
                if (idx >= n)
                    r.status = rdq_pkg::STAT_RANGE;
                else if (cmd == rdq_pkg::CMD_READ)
                    r.value = shadow_words[idx];
                else
                    shadow_words[idx] = v;
            end
            rdq_pkg::CMD_INSERT:
            begin
                // The index test wins over the full test.
                if (idx > n)
                    r.status = rdq_pkg::STAT_RANGE;
                else if (n >= CAP)
                    r.status = rdq_pkg::STAT_FULL;
                else
                    shadow_words.insert(idx, v);
            end
            rdq_pkg::CMD_ERASE:
            begin
                if (idx >= n)
                    r.status = rdq_pkg::STAT_RANGE;
                else
                    shadow_words.delete(idx);
            end
            rdq_pkg::CMD_CLEAR:
            begin
                shadow_words.delete();
            end
            rdq_pkg::CMD_FIND, rdq_pkg::CMD_REMOVE:
            begin
                r.status = rdq_pkg::STAT_NOTFOUND;
                for (i = 0; i < n; i++)
                begin
                    if (shadow_words[i] == v)
                    begin
                        r.status = rdq_pkg::STAT_OK;
                        r.found  = 6'(i);
                        if (cmd == rdq_pkg::CMD_REMOVE)
                            shadow_words.delete(i);
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = 7'(shadow_words.size());
        return r;
    endfunction

    // Offers one transaction after a random gap (none in a quiet phase) and books its expected result once taken.
    task automatic issue(rdq_pkg::cmd_t cmd, logic [6:0] pos, logic [31:0] v, bit typed,
                         result_word_t want, bit drain_first);
        int           gap;
        cmd_word_t    word;
        result_word_t predicted;
        gap = quiet_phase ? 0 : $urandom_range(0, 7);
        if (gap > 0 || drain_first)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain_first)
            begin
                while (pending_results.size() != 0) @(posedge clk);
                @(posedge clk);
            end
        end
        word.pad      = '0;
        word.value    = v;
        word.position = pos;
        word.command  = cmd;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = deque_apply(cmd, pos, v);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
        if (predicted.status == rdq_pkg::STAT_FULL)
            full_refusals++;
        if ((cmd == rdq_pkg::CMD_FIND || cmd == rdq_pkg::CMD_REMOVE) &&
            predicted.status == rdq_pkg::STAT_OK)
            search_hits++;
        if (int'(predicted.count) > peak_count)
            peak_count = int'(predicted.count);
    endtask

    initial
    begin : result_sink
        int           stall;
        bit           held;
        result_word_t got;
        result_word_t want;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // One long hold-off keeps the result register full and stalls the block's input.
            if (!held && checked_count == HOLD_AT)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = quiet_phase ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got = result_word_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (mismatch_count < 10)
                    $display("unexpected transaction on result side: %h", got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (got.value !== want.value || got.found !== want.found ||
                    got.count !== want.count || got.status !== want.status)
                begin
                    fail_count++;
                    if (mismatch_count < 10)
                    begin
                        $display("result %0d: expected st=%0d cnt=%0d pos=%0d val=%h",
                                 checked_count, want.status, want.count, want.found,
                                 want.value);
                        $display("result %0d: got      st=%0d cnt=%0d pos=%0d val=%h",
                                 checked_count, got.status, got.count, got.found,
                                 got.value);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int            i;
        int            ep;
        int            n;
        int            roll;
        int            sel;
        mode_t         mode;
        rdq_pkg::cmd_t cmd;
        logic [6:0]    pos;
        logic [31:0]   v;

        directed_rows = '{
            '{rdq_pkg::CMD_POP_BACK,   7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_EMPTY,    7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_POP_FRONT,  7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_EMPTY,    7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_READ,       7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_RANGE,    7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_ERASE,      7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_RANGE,    7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_INSERT,     7'd1,  32'h0,        1'b1,
              '{rdq_pkg::STAT_RANGE,    7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_FIND,       7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_NOTFOUND, 7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_REMOVE,     7'd0,  32'hFFFFFFFF, 1'b1,
              '{rdq_pkg::STAT_NOTFOUND, 7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_INSERT,     7'd0,  32'hFFFFFFFF, 1'b1,
              '{rdq_pkg::STAT_OK,       7'd1, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_PUSH_FRONT, 7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_OK,       7'd2, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_READ,       7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_OK,       7'd2, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_READ,       7'd1,  32'h0,        1'b1,
              '{rdq_pkg::STAT_OK,       7'd2, 6'd0, 32'hFFFFFFFF}},
            '{rdq_pkg::CMD_READ,       7'd64, 32'h0,        1'b1,
              '{rdq_pkg::STAT_RANGE,    7'd2, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_WRITE,      7'd1,  32'h12345678, 1'b1,
              '{rdq_pkg::STAT_OK,       7'd2, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_PUSH_BACK,  7'd0,  32'hA5A5A5A5, 1'b1,
              '{rdq_pkg::STAT_OK,       7'd3, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_INSERT,     7'd2,  32'h5A5A5A5A, 1'b0, '0},
            '{rdq_pkg::CMD_INSERT,     7'd1,  32'hFFFFFFFF, 1'b0, '0},
            '{rdq_pkg::CMD_PUSH_BACK,  7'd0,  32'hFFFFFFFF, 1'b0, '0},
            '{rdq_pkg::CMD_FIND,       7'd0,  32'hFFFFFFFF, 1'b0, '0},
            '{rdq_pkg::CMD_REMOVE,     7'd0,  32'hA5A5A5A5, 1'b0, '0},
            '{rdq_pkg::CMD_ERASE,      7'd1,  32'h0,        1'b0, '0},
            '{rdq_pkg::CMD_WRITE,      7'd64, 32'h0,        1'b0, '0},
            '{rdq_pkg::CMD_POP_BACK,   7'd0,  32'h0,        1'b0, '0},
            '{rdq_pkg::CMD_POP_FRONT,  7'd0,  32'h0,        1'b0, '0},
            '{rdq_pkg::CMD_CLEAR,      7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_OK,       7'd0, 6'd0, 32'h0}},
            '{rdq_pkg::CMD_FIND,       7'd0,  32'h0,        1'b1,
              '{rdq_pkg::STAT_NOTFOUND, 7'd0, 6'd0, 32'h0}}
        };

        mode = MODE_FILL;
        ep   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
            issue(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].want, 1'b0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // The first episode always runs in fill mode, to reach refusals at capacity.
            if (i % EPISODE_LEN == 0)
            begin
                ep          = i / EPISODE_LEN;
                mode        = (ep == 0) ? MODE_FILL : mode_t'($urandom_range(0, 2));
                quiet_phase = (ep % 4 == 2);
            end
            n    = shadow_words.size();
            roll = $urandom_range(0, 99);
            if (roll == 0 && ep != 0)
                cmd = rdq_pkg::CMD_CLEAR;
            else
            begin
                case (mode)
                    MODE_FILL:
                    begin
                        if (roll < 26)      cmd = rdq_pkg::CMD_PUSH_BACK;
                        else if (roll < 46) cmd = rdq_pkg::CMD_PUSH_FRONT;
                        else if (roll < 60) cmd = rdq_pkg::CMD_INSERT;
                        else if (roll < 68) cmd = rdq_pkg::CMD_READ;
                        else if (roll < 76) cmd = rdq_pkg::CMD_WRITE;
                        else if (roll < 84) cmd = rdq_pkg::CMD_FIND;
                        else if (roll < 90) cmd = rdq_pkg::CMD_REMOVE;
                        else if (roll < 94) cmd = rdq_pkg::CMD_ERASE;
                        else if (roll < 97) cmd = rdq_pkg::CMD_POP_BACK;
                        else                cmd = rdq_pkg::CMD_POP_FRONT;
                    end
                    MODE_DRAIN:
                    begin
                        if (roll < 8)       cmd = rdq_pkg::CMD_PUSH_BACK;
                        else if (roll < 14) cmd = rdq_pkg::CMD_PUSH_FRONT;
                        else if (roll < 20) cmd = rdq_pkg::CMD_INSERT;
                        else if (roll < 28) cmd = rdq_pkg::CMD_READ;
                        else if (roll < 34) cmd = rdq_pkg::CMD_WRITE;
                        else if (roll < 44) cmd = rdq_pkg::CMD_FIND;
                        else if (roll < 58) cmd = rdq_pkg::CMD_REMOVE;
                        else if (roll < 72) cmd = rdq_pkg::CMD_ERASE;
                        else if (roll < 86) cmd = rdq_pkg::CMD_POP_BACK;
                        else                cmd = rdq_pkg::CMD_POP_FRONT;
                    end
                    default:
                    begin
                        cmd = rdq_pkg::cmd_t'(4'($urandom_range(0, 9)));
                        if (cmd == rdq_pkg::CMD_CLEAR)
                            cmd = rdq_pkg::CMD_REMOVE;
                    end
                endcase
            end

            // Mostly legal positions, with a share reaching past the count.
            if ($urandom_range(0, 6) == 0)
                pos = 7'($urandom_range(0, CAP));
            else
                pos = 7'($urandom_range(0, n));

            // Reusing stored words gives duplicates and hits for find and remove.
            sel = $urandom_range(0, 9);
            if (sel < 4 && n > 0)
                v = shadow_words[$urandom_range(0, n - 1)];
            else if (sel == 4)
                v = '0;
            else if (sel == 5)
                v = '1;
            else
                v = $urandom;

            issue(cmd, pos, v, 1'b0, '0, i == PAUSE_AT);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d directed), checked %0d results, %0d mismatches.",
                 sent_count, NUM_ROWS, checked_count, mismatch_count);
        $display("Peak occupancy %0d of %0d, %0d refused while full, %0d find/remove hits.",
                 peak_count, CAP, full_refusals, search_hits);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rdq_pkg.sv
src/rdq_cell.sv
src/ring_deque_indexed_table_core.sv
bench/tb_ring_deque_indexed_table_core.sv
